### sv/toroidal_life_generation_step_top_assert.svh
// -----------------------------------------------------------------------------
// Assertion macros shared by the toroidal life generation step modules.
// Each macro expands to one labeled concurrent assertion, reset-qualified.
// The assertions sample on clk and are disabled while rst_n is low.
// -----------------------------------------------------------------------------
`ifndef TOROIDAL_LIFE_GENERATION_STEP_TOP_ASSERT_SVH
`define TOROIDAL_LIFE_GENERATION_STEP_TOP_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define TLG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define TLG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/tlg_pkg.sv
// -----------------------------------------------------------------------------
// tlg_pkg
// Types and constants of the toroidal life generation step block.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tlg_pkg;

  // Field widths.
  localparam int ROW_W = 64;
  localparam int IDX_W = 6;
  localparam int CFG_W = 7;
  localparam int GEN_W = 32;

  // Input command codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  // Input item.
  typedef struct packed {
    logic             command;
    logic [IDX_W-1:0] row_index;
    logic [ROW_W-1:0] row_cells;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [IDX_W-1:0] out_row_index;
    logic [ROW_W-1:0] out_row_cells;
    logic [GEN_W-1:0] generation;
    logic             last_row;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             advance;     // sweep pipeline moves this cycle
    logic             load_wr;     // store the accepted load row
    logic             step_start;  // a step item was accepted
    logic             sweep;       // sweep in progress
    logic             fetch;       // read a board row
    logic [IDX_W-1:0] fetch_addr;
    logic             save_row0;   // keep the old first row for the wrap
    logic             compute;     // a new row is produced
    logic             use_saved;   // last row: lower neighbor is old row 0
    logic [IDX_W-1:0] row_idx;     // row being produced
  } tlg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;
  } tlg_sts_t;

endpackage

`default_nettype wire

### sv/toroidal_life_generation_step_top.sv
// -----------------------------------------------------------------------------
// toroidal_life_generation_step_top
// Toroidal Conway life board: loads rows, steps one generation, emits rows.
//
//   Channel  Ports                             Moves
//   input    in_valid, in_ready, in_item       load row or step command
//   result   out_valid, out_ready, out_item    one new board row per item
//   config   cfg_we, cfg_index, cfg_wdata      rows_used, cols_used
//
// A load item is written to the board in the cycle it is accepted, and loads can
// follow back to back. A step item sweeps the board through one memory read port,
// one row per cycle while the result is not stalled, and the input reopens once
// the sweep has produced its last row.
// A stalled result freezes the whole sweep pipeline.
// Reset clears the per-row valid bits at once; there is no clearing pass.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module toroidal_life_generation_step_top
  import tlg_pkg::*;
#(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_item_t         in_item,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_item,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  logic [CFG_W-1:0] rows_used_r;
  logic [CFG_W-1:0] cols_used_r;
  logic [CFG_W-1:0] rows_eff;
  logic [CFG_W-1:0] cols_eff;
  tlg_cmd_t         cmd;
  tlg_sts_t         sts;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_used_r <= CFG_W'(20);
      cols_used_r <= CFG_W'(20);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROWS: rows_used_r <= cfg_wdata;
        CFG_COLS: cols_used_r <= cfg_wdata;
        default:  rows_used_r <= rows_used_r;
      endcase
    end
  end

  // Saturate the board size to 1 .. maximum.
  assign rows_eff = (rows_used_r == '0) ? CFG_W'(1) :
                    (rows_used_r > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : rows_used_r;
  assign cols_eff = (cols_used_r == '0) ? CFG_W'(1) :
                    (cols_used_r > CFG_W'(MAX_COLS)) ? CFG_W'(MAX_COLS) : cols_used_r;

  tlg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .rows_eff (rows_eff),
    .sts      (sts),
    .cmd      (cmd)
  );

  tlg_dpath #(
    .MAX_ROWS (MAX_ROWS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_item   (in_item),
    .cols_eff  (cols_eff),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

### sv/tlg_ctrl.sv
// -----------------------------------------------------------------------------
// tlg_ctrl
// Controller: accepts items, sequences the row sweep of a step command.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "toroidal_life_generation_step_top_assert.svh"

module tlg_ctrl
  import tlg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_item_t         in_item,
  input  wire logic [CFG_W-1:0] rows_eff,
  input  wire tlg_sts_t         sts,
  output tlg_cmd_t              cmd
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_SWEEP = 1'b1;

  logic             state_r, state_nxt;
  logic [CFG_W-1:0] t_r, t_nxt;
  logic             accept;
  logic             advance;
  logic [CFG_W-1:0] last_t;
  logic [CFG_W-1:0] addr_full;
  logic [CFG_W-1:0] row_full;

  // The sweep moves whenever the output register can take a row.
  assign advance  = !sts.out_busy;
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign last_t   = rows_eff + CFG_W'(2);

  // Fetch the last row first, then rows from the top; the produced row index is
  // the fetch counter minus three.
  assign addr_full = (t_r == '0) ? (rows_eff - CFG_W'(1)) : (t_r - CFG_W'(1));
  assign row_full  = t_r - CFG_W'(3);

  always_comb begin
    cmd            = '0;
    cmd.advance    = advance;
    cmd.load_wr    = accept && (in_item.command == CMD_LOAD) &&
                     ({1'b0, in_item.row_index} < rows_eff);
    cmd.step_start = accept && (in_item.command == CMD_STEP);
    cmd.sweep      = (state_r == ST_SWEEP);
    cmd.fetch      = cmd.sweep && (t_r <= rows_eff);
    cmd.fetch_addr = addr_full[IDX_W-1:0];
    cmd.save_row0  = cmd.sweep && (t_r == CFG_W'(2));
    cmd.compute    = cmd.sweep && (t_r >= CFG_W'(3));
    cmd.use_saved  = cmd.sweep && (t_r == last_t);
    cmd.row_idx    = row_full[IDX_W-1:0];
  end

  // State and sweep counter.
  always_comb begin
    state_nxt = state_r;
    t_nxt     = t_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.step_start) begin
          state_nxt = ST_SWEEP;
          t_nxt     = '0;
        end
      end
      ST_SWEEP: begin
        if (advance) begin
          t_nxt = t_r + CFG_W'(1);
          if (t_r == last_t) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      t_r     <= '0;
    end else begin
      state_r <= state_nxt;
      t_r     <= t_nxt;
    end
  end

  // The sweep counter never runs past the final produced row.
  `TLG_ASSERT_NOW(a_t_bound, state_r == ST_SWEEP, t_r <= last_t, "sweep overrun")
  // An accepted step starts a sweep from the first fetch.
  `TLG_ASSERT_NEXT(a_step_start, cmd.step_start, state_r == ST_SWEEP && t_r == '0, "step lost")
  // A fetch never reads the row that is being written back.
  `TLG_ASSERT_NOW(a_rw_apart, cmd.fetch && cmd.compute, cmd.fetch_addr != cmd.row_idx, "row clash")

endmodule

`default_nettype wire

### sv/tlg_dpath.sv
// -----------------------------------------------------------------------------
// tlg_dpath
// Datapath: board memory, three-row window, life rule, output register.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "toroidal_life_generation_step_top_assert.svh"

module tlg_dpath
  import tlg_pkg::*;
#(
  parameter int MAX_ROWS = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire tlg_cmd_t         cmd,
  output tlg_sts_t              sts,
  input  wire in_item_t         in_item,
  input  wire logic [CFG_W-1:0] cols_eff,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_item
);

  localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  // Board memory with one valid bit per row; an unwritten row reads dead.
  logic [ROW_W-1:0] mem [MAX_ROWS];
  logic [MAX_ROWS-1:0] row_vld_r;
  logic [ROW_W-1:0] rd_data_r;
  logic             rd_vld_r;
  logic             rd_en;
  logic             wr_en;
  logic [RAW-1:0]   wr_addr;
  logic [ROW_W-1:0] wr_data;
  logic [ROW_W-1:0] rd_row;

  // Window and generation.
  logic [ROW_W-1:0] prev_r;
  logic [ROW_W-1:0] cur_r;
  logic [ROW_W-1:0] row0_r;
  logic [ROW_W-1:0] next_row;
  logic [GEN_W-1:0] gen_r;

  // Life rule.
  logic [ROW_W-1:0] col_mask;
  logic [ROW_W-1:0] last_oh;
  logic [IDX_W-1:0] last_col;
  logic [ROW_W-1:0] new_row;
  logic             wb_en;

  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r;

  // Neighbor one column to the left, wrapping at the last column in use.
  function automatic logic [ROW_W-1:0] wrap_left(input logic [ROW_W-1:0] row,
                                                 input logic [IDX_W-1:0] lc);
    return {row[ROW_W-2:0], row[lc]};
  endfunction

  // Neighbor one column to the right, wrapping to column zero.
  function automatic logic [ROW_W-1:0] wrap_right(input logic [ROW_W-1:0] row,
                                                  input logic [ROW_W-1:0] oh);
    return ({1'b0, row[ROW_W-1:1]} & ~oh) | (oh & {ROW_W{row[0]}});
  endfunction

  assign col_mask = ~({ROW_W{1'b1}} << cols_eff);
  assign last_col = IDX_W'(cols_eff - CFG_W'(1));
  assign last_oh  = ROW_W'(1) << last_col;

  // Memory ports: one read for the sweep, one write shared by load and write-back.
  assign rd_en   = cmd.fetch && cmd.advance;
  assign wb_en   = cmd.compute && cmd.advance;
  assign wr_en   = cmd.load_wr || wb_en;
  assign wr_addr = cmd.load_wr ? in_item.row_index[RAW-1:0] : cmd.row_idx[RAW-1:0];
  assign wr_data = cmd.load_wr ? (in_item.row_cells & col_mask) : new_row;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[cmd.fetch_addr[RAW-1:0]];
      rd_vld_r  <= row_vld_r[cmd.fetch_addr[RAW-1:0]];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (wr_en) begin
      row_vld_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_row = rd_vld_r ? rd_data_r : '0;

  // The window shifts on every advancing sweep cycle; old row 0 is kept for the wrap.
  always_ff @(posedge clk) begin
    if (cmd.sweep && cmd.advance) begin
      prev_r <= cur_r;
      cur_r  <= rd_row;
      if (cmd.save_row0) begin
        row0_r <= rd_row;
      end
    end
  end

  assign next_row = cmd.use_saved ? row0_r : rd_row;

  // Count the eight neighbors of every column and apply the birth and survival rule.
  always_comb begin
    logic [ROW_W-1:0] pl, pr, cl, cr, nl, nr;
    logic [3:0]       n;
    pl = wrap_left(prev_r, last_col);
    pr = wrap_right(prev_r, last_oh);
    cl = wrap_left(cur_r, last_col);
    cr = wrap_right(cur_r, last_oh);
    nl = wrap_left(next_row, last_col);
    nr = wrap_right(next_row, last_oh);
    new_row = '0;
    for (int c = 0; c < ROW_W; c++) begin
      n = {3'b0, pl[c]} + {3'b0, prev_r[c]} + {3'b0, pr[c]} +
          {3'b0, cl[c]} + {3'b0, cr[c]} +
          {3'b0, nl[c]} + {3'b0, next_row[c]} + {3'b0, nr[c]};
      new_row[c] = (n == 4'd3) || (cur_r[c] && (n == 4'd2));
    end
    new_row = new_row & col_mask;
  end

  // Generation counter advances once per step item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r <= '0;
    end else if (cmd.step_start) begin
      gen_r <= gen_r + GEN_W'(1);
    end
  end

  // Output register: whenever the pipeline advances, it takes the written-back row or goes empty.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.advance) begin
      out_valid_nxt = wb_en;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_en) begin
      out_item_r.out_row_index <= cmd.row_idx;
      out_item_r.out_row_cells <= new_row;
      out_item_r.generation    <= gen_r;
      out_item_r.last_row      <= cmd.use_saved;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_item     = out_item_r;
  assign sts.out_busy = out_valid_r && !out_ready;

  // A load and a write-back never compete for the write port.
  `TLG_ASSERT_NOW(a_one_writer, cmd.load_wr, !wb_en, "write port conflict")
  // Each step item moves the generation count by exactly one.
  `TLG_ASSERT_NEXT(a_gen_inc, cmd.step_start, gen_r == $past(gen_r) + GEN_W'(1), "gen skipped")
  // A waiting result stays valid and unchanged until it is taken.
  `TLG_ASSERT_NEXT(a_out_hold, sts.out_busy, out_valid_r && $stable(out_item_r), "result lost")

endmodule

`default_nettype wire
